### design/fscan_disk_request_scheduler_top_macros.svh
// Assertion macros for the FSCAN request scheduler.
`ifndef FSCAN_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define FSCAN_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FDS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FDS_ASSERT_IMP(label, clk, rst, ante, cons)
`define FDS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/fscan_pkg.sv
// Shared types and codes for the FSCAN request scheduler.
`default_nettype none
package fscan_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SERVE = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  // Spare command code: answered with nothing pending, no state change
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_SERVED = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PICK, S_SHIFT, S_DONE
  } state_t;

  typedef struct packed {
    logic add;
    logic restart;
    logic nothing;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic shift_start;
    logic shift_step;
    logic finish;
    logic set_result;
    logic [1:0] result_status;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic match;
    logic shift_last;
  } sts_t;
endpackage
`default_nettype wire

### design/fscan_disk_request_scheduler_top.sv
// Top level of the FSCAN disk request scheduler.
// Input channel in_valid/in_ready carries command and track; one result beat
// per command leaves on out_valid/out_ready. Config channel cfg_valid/cfg_ready
// writes head_start_track and is always ready.
// Add, restart, unused commands and a serve on an empty store give their
// result the cycle after the beat is taken.
// A serve scans the frozen batch one entry per cycle from the store's single
// read port up to the first exact match, then chooses in the pick state,
// then compacts the entries behind the chosen one, one per cycle, then shows
// the result.
// One item is in flight at a time. Reset empties the store, idles the head
// at track zero, zeroes the start track and clears the totals. When the
// receiver stalls the result is held and no new command is taken.
`default_nettype none
module fscan_disk_request_scheduler_top #(
  parameter int BUFFER_DEPTH = 64,
  parameter int TRACK_COUNT = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [11:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] command,
  input  wire logic [11:0] track,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] status,
  output logic [11:0] served_track,
  output logic [11:0] seek_distance,
  output logic [1:0] sweep_direction,
  output logic [31:0] total_traversed,
  output logic [31:0] total_served
);
  import fscan_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic [11:0] head_start_track;

  assign cfg_ready = 1'b1;
  // Hold the start track register
  always_ff @(posedge clk) begin
    if (rst) head_start_track <= '0;
    else if (cfg_valid) head_start_track <= cfg_data;
  end

  fscan_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .command, .out_valid, .out_ready,
    .sts, .ctl
  );

  fscan_dp #(.BUFFER_DEPTH(BUFFER_DEPTH), .TRACK_COUNT(TRACK_COUNT)) u_dp (
    .clk, .rst, .ctl, .sts, .head_start_track, .track, .status,
    .served_track, .seek_distance, .sweep_direction, .total_traversed,
    .total_served
  );
endmodule
`default_nettype wire

### design/fscan_ctrl.sv
// Controller state machine for the FSCAN request scheduler.
`default_nettype none
module fscan_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] command,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire fscan_pkg::sts_t sts,
  output fscan_pkg::ctl_t ctl
);
  import fscan_pkg::*;
  `include "fscan_disk_request_scheduler_top_macros.svh"

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_DONE;
          ctl.set_result = 1'b1;
          ctl.result_status = ST_NONE;
          case (command)
            CMD_ADD: begin
              ctl.add = ~sts.full;
              ctl.result_status = sts.full ? ST_FULL : ST_ADDED;
            end
            CMD_SERVE: begin
              if (sts.empty) begin
                ctl.nothing = 1'b1;
              end else begin
                ctl.set_result = 1'b0;
                ctl.scan_start = 1'b1;
                state_next = S_SCAN;
              end
            end
            CMD_RESTART: begin
              ctl.restart = 1'b1;
            end
            default: ctl.result_status = ST_NONE;
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.match || sts.scan_last) state_next = S_PICK;
      end
      S_PICK: begin
        ctl.pick = 1'b1;
        ctl.shift_start = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_last) begin
          ctl.finish = 1'b1;
          ctl.set_result = 1'b1;
          ctl.result_status = ST_SERVED;
          state_next = S_DONE;
        end else begin
          ctl.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `FDS_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `FDS_ASSERT_NXT(a_scan_goes, clk, rst, ctl.scan_start, state == S_SCAN)
  `FDS_ASSERT_IMP(a_out_done, clk, rst, out_valid, !in_ready)
endmodule
`default_nettype wire

### design/fscan_dp.sv
// Datapath of the FSCAN request scheduler: store, scan, compaction, totals.
`default_nettype none
module fscan_dp #(
  parameter int BUFFER_DEPTH = 64,
  parameter int TRACK_COUNT = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fscan_pkg::ctl_t ctl,
  output fscan_pkg::sts_t sts,
  input  wire logic [11:0] head_start_track,
  input  wire logic [11:0] track,
  output logic [1:0] status,
  output logic [11:0] served_track,
  output logic [11:0] seek_distance,
  output logic [1:0] sweep_direction,
  output logic [31:0] total_traversed,
  output logic [31:0] total_served
);
  import fscan_pkg::*;
  `include "fscan_disk_request_scheduler_top_macros.svh"

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [11:0] TMAX = (TRACK_COUNT >= 4096) ? 12'hFFF : 12'(TRACK_COUNT - 1);

  logic [11:0] mem [BUFFER_DEPTH];
  logic [CW-1:0] stored_count, frozen_count, limit, eff_frozen;
  logic [11:0] head_track;
  logic [1:0] head_dir;
  logic [31:0] traversed_sum, served_sum;
  logic [32:0] trav_sum;
  logic [CW-1:0] rd_idx, data_idx, wr_idx;
  logic [11:0] rd_data;
  logic rd_valid;
  logic [CW-1:0] near_idx, above_idx, below_idx, match_idx, psel;
  logic [11:0] near_d, above_d, below_d, near_t, above_t, below_t;
  logic have_above, have_below, have_near, match_hit;
  logic [11:0] pick_t, pick_seek;
  logic [1:0] pick_dir;
  logic [11:0] res_track, res_seek, served_q, seek_q;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [11:0] mem_wd;
  logic [11:0] dlt;
  logic up;

  function automatic logic [11:0] clampt(input logic [11:0] t);
    return (t > TMAX) ? TMAX : t;
  endfunction

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  assign mem_ra = rd_idx[AW-1:0];

  // Steer the write port: append on add, move down one slot on compaction
  always_comb begin
    mem_we = 1'b0;
    mem_wa = stored_count[AW-1:0];
    mem_wd = clampt(track);
    if (ctl.add) mem_we = 1'b1;
    if (rd_valid && ctl.shift_step) begin
      mem_we = 1'b1;
      mem_wa = wr_idx[AW-1:0];
      mem_wd = rd_data;
    end
  end

  assign up = rd_data > head_track;
  assign dlt = up ? rd_data - head_track : head_track - rd_data;
  assign eff_frozen = (frozen_count == '0 || frozen_count > stored_count) ? stored_count
                      : frozen_count;
  assign trav_sum = {1'b0, traversed_sum} + {21'd0, res_seek};

  always_comb begin
    sts.full = stored_count == CW'(BUFFER_DEPTH);
    sts.empty = stored_count == '0;
    sts.match = rd_valid && ctl.scan_step && (rd_data == head_track);
    sts.scan_last = rd_valid && ctl.scan_step && (data_idx == limit - 1'b1);
    sts.shift_last = !rd_valid && (rd_idx >= stored_count);
  end

  // Choose the entry to serve and the new sweep direction
  always_comb begin
    psel = near_idx;
    pick_t = near_t;
    pick_dir = (near_t > head_track) ? DIR_UP : DIR_DOWN;
    if (match_hit) begin
      psel = match_idx;
      pick_t = head_track;
      pick_dir = head_dir;
    end else if (head_dir == DIR_UP) begin
      if (have_above) begin
        psel = above_idx; pick_t = above_t; pick_dir = DIR_UP;
      end else begin
        psel = below_idx; pick_t = below_t; pick_dir = DIR_DOWN;
      end
    end else if (head_dir == DIR_DOWN) begin
      if (have_below) begin
        psel = below_idx; pick_t = below_t; pick_dir = DIR_DOWN;
      end else begin
        psel = above_idx; pick_t = above_t; pick_dir = DIR_UP;
      end
    end
  end

  assign pick_seek = (pick_t > head_track) ? pick_t - head_track : head_track - pick_t;

  // Scan the frozen batch one entry per cycle; compact one entry per cycle; keep counts, head and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      frozen_count <= '0;
      head_track <= '0;
      head_dir <= DIR_IDLE;
      traversed_sum <= '0;
      served_sum <= '0;
      rd_valid <= 1'b0;
      status <= ST_NONE;
      served_q <= '0;
      seek_q <= '0;
    end else begin
      if (ctl.add) stored_count <= stored_count + 1'b1;
      if (ctl.restart) begin
        head_track <= clampt(head_start_track);
        head_dir <= DIR_IDLE;
        traversed_sum <= '0;
        served_sum <= '0;
      end
      if (ctl.nothing) head_dir <= DIR_IDLE;
      if (ctl.scan_start) begin
        frozen_count <= eff_frozen;
        limit <= eff_frozen;
        rd_idx <= '0;
        rd_valid <= 1'b0;
        have_above <= 1'b0;
        have_below <= 1'b0;
        have_near <= 1'b0;
        match_hit <= 1'b0;
      end
      if (ctl.scan_step) begin
        // Issue the next read, then sort the entry that just arrived
        rd_valid <= rd_idx < limit;
        data_idx <= rd_idx;
        rd_idx <= rd_idx + 1'b1;
        if (rd_valid) begin
          if (rd_data == head_track) begin
            match_hit <= 1'b1;
            match_idx <= data_idx;
          end else begin
            if (up) begin
              if (!have_above || dlt < above_d) begin
                have_above <= 1'b1; above_d <= dlt; above_t <= rd_data; above_idx <= data_idx;
              end
            end else if (!have_below || dlt < below_d) begin
              have_below <= 1'b1; below_d <= dlt; below_t <= rd_data; below_idx <= data_idx;
            end
            if (!have_near || dlt < near_d) begin
              have_near <= 1'b1; near_d <= dlt; near_t <= rd_data; near_idx <= data_idx;
            end
          end
        end
      end
      if (ctl.pick) begin
        head_dir <= pick_dir;
        res_track <= pick_t;
        res_seek <= pick_seek;
      end
      if (ctl.shift_start) begin
        rd_idx <= psel + 1'b1;
        wr_idx <= psel;
        rd_valid <= 1'b0;
      end
      if (ctl.shift_step) begin
        if (rd_idx < stored_count) begin
          rd_valid <= 1'b1;
          rd_idx <= rd_idx + 1'b1;
        end else begin
          rd_valid <= 1'b0;
        end
        if (rd_valid) wr_idx <= wr_idx + 1'b1;
      end
      if (ctl.finish) begin
        stored_count <= stored_count - 1'b1;
        frozen_count <= frozen_count - 1'b1;
        head_track <= res_track;
        traversed_sum <= trav_sum[32] ? '1 : trav_sum[31:0];
        served_sum <= (served_sum == '1) ? served_sum : served_sum + 1'b1;
      end
      // Load the result beat
      if (ctl.set_result) begin
        status <= ctl.result_status;
        served_q <= ctl.finish ? res_track : '0;
        seek_q <= ctl.finish ? res_seek : '0;
      end
    end
  end

  assign served_track = served_q;
  assign seek_distance = seek_q;
  assign sweep_direction = head_dir;
  assign total_traversed = traversed_sum;
  assign total_served = served_sum;

  `FDS_ASSERT_IMP(a_cnt, clk, rst, 1'b1, frozen_count <= stored_count)
  `FDS_ASSERT_IMP(a_add, clk, rst, ctl.add, !sts.full)
  `FDS_ASSERT_NXT(a_fin, clk, rst, ctl.finish, status == ST_SERVED)
endmodule
`default_nettype wire

### bench/fscan_checker.sv
// Checker for the FSCAN scheduler: tracks state, predicts each result, compares.
`timescale 1ns / 1ps
module fscan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [11:0] track,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [11:0] served_track,
  input  logic [11:0] seek_distance,
  input  logic [1:0]  sweep_direction,
  input  logic [31:0] total_traversed,
  input  logic [31:0] total_served,
  output int          fail_count,
  output int          pending_results,
  output int          queued_tracks
);
  import fscan_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] track;
    logic [11:0] seek;
    logic [1:0]  dir;
    logic [31:0] traversed;
    logic [31:0] served;
  } sched_result_t;

  sched_result_t result_fifo[$];
  logic [11:0] start_track;
  logic [11:0] tracks_q[$];
  int          batch_left;
  logic [11:0] head;
  logic [1:0]  heading;
  logic [31:0] traversed_acc;
  logic [31:0] served_acc;

  assign pending_results = result_fifo.size();
  assign queued_tracks = tracks_q.size();

  // Pick the next track from the frozen batch and update the heading.
  function automatic int choose_slot();
    int up_i, dn_i, nr_i;
    int up_d, dn_d, nr_d, d;
    up_i = -1; dn_i = -1; nr_i = -1;
    up_d = 0; dn_d = 0; nr_d = 0;
    for (int i = 0; i < batch_left; i++) begin
      if (tracks_q[i] == head) begin
        return i;
      end
      d = (tracks_q[i] > head) ? tracks_q[i] - head : head - tracks_q[i];
      if (tracks_q[i] > head) begin
        if (up_i < 0 || d < up_d) begin
          up_i = i; up_d = d;
        end
      end else if (dn_i < 0 || d < dn_d) begin
        dn_i = i; dn_d = d;
      end
      if (nr_i < 0 || d < nr_d) begin
        nr_i = i; nr_d = d;
      end
    end
    if (heading == DIR_UP) begin
      if (up_i >= 0) return up_i;
      heading = DIR_DOWN;
      return dn_i;
    end
    if (heading == DIR_DOWN) begin
      if (dn_i >= 0) return dn_i;
      heading = DIR_UP;
      return up_i;
    end
    heading = (tracks_q[nr_i] > head) ? DIR_UP : DIR_DOWN;
    return nr_i;
  endfunction

  function automatic sched_result_t predict_command(logic [1:0] cmd, logic [11:0] trk);
    sched_result_t r;
    int slot;
    r = '0;
    r.status = ST_NONE;
    if (cmd == CMD_ADD) begin
      if (tracks_q.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        tracks_q.insert(tracks_q.size(), trk);
        r.status = ST_ADDED;
      end
    end else if (cmd == CMD_SERVE) begin
      if (tracks_q.size() == 0) begin
        heading = DIR_IDLE;
      end else begin
        if (batch_left == 0 || batch_left > tracks_q.size()) batch_left = tracks_q.size();
        slot = choose_slot();
        if (slot < 0 || slot >= tracks_q.size()) slot = 0;
        r.track = tracks_q[slot];
        r.seek = (r.track > head) ? r.track - head : head - r.track;
        tracks_q.delete(slot);
        batch_left--;
        head = r.track;
        traversed_acc = (traversed_acc + r.seek < traversed_acc) ? 32'hFFFF_FFFF
                                                                 : traversed_acc + r.seek;
        served_acc = (served_acc == 32'hFFFF_FFFF) ? served_acc : served_acc + 1;
        r.status = ST_SERVED;
      end
    end else if (cmd == CMD_RESTART) begin
      head = start_track;
      heading = DIR_IDLE;
      traversed_acc = '0;
      served_acc = '0;
    end
    r.dir = heading;
    r.traversed = traversed_acc;
    r.served = served_acc;
    return r;
  endfunction

  // Track accepted beats, predict, and compare results.
  always @(posedge clk) begin
    sched_result_t got, want;
    if (rst) begin
      result_fifo.delete();
      tracks_q.delete();
      start_track <= '0;
      batch_left = 0;
      head = '0;
      heading = DIR_IDLE;
      traversed_acc = '0;
      served_acc = '0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) start_track <= cfg_data;
      if (in_valid && in_ready)
        result_fifo.insert(result_fifo.size(), predict_command(command, track));
      if (out_valid && out_ready) begin
        got = {status, served_track, seek_distance, sweep_direction,
               total_traversed, total_served};
        if (result_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected st=%0d trk=%0d seek=%0d dir=%0d tot=%0d n=%0d",
                       want.status, want.track, want.seek, want.dir, want.traversed,
                       want.served);
              $display("          got      st=%0d trk=%0d seek=%0d dir=%0d tot=%0d n=%0d",
                       got.status, got.track, got.seek, got.dir, got.traversed,
                       got.served);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### bench/tb_top.sv
// Stimulus and verdict for the FSCAN scheduler testbench.
`timescale 1ns / 1ps
module tb_top;
  import fscan_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic [11:0] cfg_data = '0;
  logic in_valid = 0;
  logic [1:0] command = CMD_ADD;
  logic [11:0] track = '0;
  logic out_ready = 0;
  logic cfg_ready, in_ready, out_valid;
  logic [1:0] status, sweep_direction;
  logic [11:0] served_track, seek_distance;
  logic [31:0] total_traversed, total_served;
  int fail_count, pending_results, queued_tracks;
  int cycle_count = 0;
  bit stall_on = 0;

  always #6 clk = ~clk;

  fscan_disk_request_scheduler_top dut (.*);
  fscan_checker u_checker (.*);

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL fscan_disk_request_scheduler_top");
      $finish;
    end
  end

  // Receiver stalls in runs, with quiet stretches.
  always @(posedge clk) begin
    if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
    out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Send one beat and hold it until accepted.
  task automatic send_command(logic [1:0] cmd, logic [11:0] trk);
    in_valid <= 1'b1;
    command <= cmd;
    track <= trk;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_start(logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: mostly adds and serves, a few restarts and unused codes.
  task automatic random_phase(int n);
    int sent, burst, pick;
    logic [1:0] cmd;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) cmd = CMD_UNUSED;
        else if (pick < 6) cmd = CMD_RESTART;
        else if (pick < (queued_tracks > 48 ? 30 : 55)) cmd = CMD_ADD;
        else cmd = CMD_SERVE;
        send_command(cmd, 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, 63)));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_in($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_start(12'd0);
    // Directed: extremes, every command, empty serve, matches, reversal.
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_UNUSED, 12'hFFF);
    send_command(CMD_ADD, 12'hFFF);
    send_command(CMD_ADD, 12'd0);
    send_command(CMD_ADD, 12'd100);
    send_command(CMD_ADD, 12'd100);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_ADD, 12'd50);
    send_command(CMD_ADD, 12'd100);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_SERVE, 12'd0);
    send_command(CMD_RESTART, 12'd0);
    drain_results();
    write_start(12'hFFF);
    send_command(CMD_RESTART, 12'd0);
    // Fill past full.
    for (int i = 0; i < 66; i++) send_command(CMD_ADD, 12'($urandom_range(0, 4095)));
    drain_results();
    write_start(12'd2048);
    random_phase(200);
    drain_results();
    write_start(12'($urandom_range(0, 4095)));
    random_phase(320);
    drain_results();
    if (fail_count == 0) begin
      $display("PASS fscan_disk_request_scheduler_top");
    end else begin
      $display("FAIL fscan_disk_request_scheduler_top");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/fscan_pkg.sv
design/fscan_ctrl.sv
design/fscan_dp.sv
design/fscan_disk_request_scheduler_top.sv
bench/fscan_checker.sv
bench/tb_top.sv
